>>> rtl/core/tlv_record_filter_unit_macros.svh
// Assertion macros for the tag-length-value record filter.
// Taken in by the checker module; no other dependencies.
`ifndef TLV_RECORD_FILTER_UNIT_MACROS_SVH
`define TLV_RECORD_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define TLVF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TLVF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tlvf_pkg.sv
// Shared types and constants for the tag-length-value record filter.
// No dependencies; used by every design module of the block (not by the checker).
`timescale 1ns / 1ps
`default_nettype none

package tlvf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET_TAG = 2'd0;
  localparam logic [1:0] REG_FIND_MODE  = 2'd1;

  // Field and state widths, and the bit that flags the long length form.
  localparam int BYTE_W        = 8;
  localparam int PAY_W         = 31;
  localparam int LBL_W         = 2;
  localparam int LEN_LARGE_BIT = 7;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_TAG       = 2'd0,
    PH_LEN_FIRST = 2'd1,
    PH_LEN_REST  = 2'd2,
    PH_PAYLOAD   = 2'd3
  } phase_t;

  // Register settings in force.
  typedef struct packed {
    logic [BYTE_W-1:0] target_tag;
    logic              find_mode;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              last;
    logic              found;
    logic              truncated;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/tlvf_in_reg.sv
// Input register stage of the record filter: holds one accepted word.
// Depends on tlvf_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module tlvf_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            drain,
  input  wire tlvf_pkg::item_t item_in,
  output tlvf_pkg::item_t      item,
  output logic                 item_valid
);

  // Valid flag: set on load, cleared when the word moves on without a refill.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (drain) begin
      item_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tlvf_parser.sv
// Record parser of the filter: phase, length and payload counters, and the
// keep and emit decisions for the word in the input register. Uses tlvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvf_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tlvf_pkg::cfg_t  cfg,
  input  wire tlvf_pkg::item_t item,
  input  wire logic            advance,
  output logic                 has_result,
  output tlvf_pkg::result_t    result
);

  tlvf_pkg::phase_t              phase;
  tlvf_pkg::phase_t              phase_next;
  logic [tlvf_pkg::LBL_W-1:0]    length_bytes_left;
  logic [tlvf_pkg::LBL_W-1:0]    length_bytes_left_next;
  logic [tlvf_pkg::PAY_W-1:0]    payload_left;
  logic [tlvf_pkg::PAY_W-1:0]    payload_left_next;
  logic                          keep_record;
  logic                          keep_record_next;
  logic                          found_seen;
  logic                          found_seen_next;
  logic                          is_payload;
  logic                          tag_hit;
  logic                          emit;
  logic                          in_record;

  assign tag_hit = (item.data == cfg.target_tag);

  // Next state for the current byte, then the result it gives.
  always_comb begin
    phase_next             = phase;
    length_bytes_left_next = length_bytes_left;
    payload_left_next      = payload_left;
    keep_record_next       = keep_record;
    found_seen_next        = found_seen;
    is_payload             = 1'b0;

    case (phase)
      tlvf_pkg::PH_TAG: begin
        if (cfg.find_mode) begin
          keep_record_next = tag_hit && !found_seen;
          if (tag_hit) begin
            found_seen_next = 1'b1;
          end
        end else begin
          keep_record_next = !tag_hit;
        end
        phase_next = tlvf_pkg::PH_LEN_FIRST;
      end
      tlvf_pkg::PH_LEN_FIRST: begin
        // A set top bit selects the four-byte length form.
        if (item.data[tlvf_pkg::LEN_LARGE_BIT]) begin
          payload_left_next      = {{(tlvf_pkg::PAY_W-7){1'b0}}, item.data[6:0]};
          length_bytes_left_next = 2'd3;
        end else begin
          payload_left_next      = {{(tlvf_pkg::PAY_W-8){1'b0}}, item.data};
          length_bytes_left_next = 2'd1;
        end
        phase_next = tlvf_pkg::PH_LEN_REST;
      end
      tlvf_pkg::PH_LEN_REST: begin
        payload_left_next      = {payload_left[tlvf_pkg::PAY_W-9:0], item.data};
        length_bytes_left_next = length_bytes_left - 2'd1;
        if (length_bytes_left_next == '0) begin
          phase_next = (payload_left_next == '0) ? tlvf_pkg::PH_TAG
                                                 : tlvf_pkg::PH_PAYLOAD;
        end
      end
      tlvf_pkg::PH_PAYLOAD: begin
        is_payload        = 1'b1;
        payload_left_next = payload_left - {{(tlvf_pkg::PAY_W-1){1'b0}}, 1'b1};
        if (payload_left_next == '0) begin
          phase_next = tlvf_pkg::PH_TAG;
        end
      end
      default: begin
        phase_next = tlvf_pkg::PH_TAG;
      end
    endcase

    emit       = keep_record_next && (!cfg.find_mode || is_payload);
    in_record  = (phase_next != tlvf_pkg::PH_TAG);
    has_result = emit || item.last;

    result.data       = emit ? item.data : '0;
    result.byte_valid = emit;
    result.last       = item.last;
    result.found      = item.last && cfg.find_mode && found_seen_next;
    result.truncated  = item.last && in_record;

    // The final byte of a stream leaves the parser ready for a new one.
    if (item.last) begin
      phase_next             = tlvf_pkg::PH_TAG;
      length_bytes_left_next = '0;
      payload_left_next      = '0;
      keep_record_next       = 1'b0;
      found_seen_next        = 1'b0;
    end
  end

  // Parser state advances once per word that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= tlvf_pkg::PH_TAG;
      length_bytes_left <= '0;
      payload_left      <= '0;
      keep_record       <= 1'b0;
      found_seen        <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      length_bytes_left <= length_bytes_left_next;
      payload_left      <= payload_left_next;
      keep_record       <= keep_record_next;
      found_seen        <= found_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tlvf_out_reg.sv
// Result register of the record filter: holds one word for the receiver.
// Depends on tlvf_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module tlvf_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tlvf_pkg::result_t result_in,
  input  wire logic              take,
  output tlvf_pkg::result_t      result,
  output logic                   result_valid,
  output logic                   free
);

  // The register can take a new word when empty or being emptied this cycle.
  assign free = !result_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tlv_record_filter_unit.sv
// Tag-length-value record filter, top level.
// Instantiates tlvf_in_reg, tlvf_parser and tlvf_out_reg; uses tlvf_pkg.
//
// Usage:
// The input channel (in_valid/in_ready) carries one stream byte per word,
// with in_last on the final byte of a stream. The output channel
// (out_valid/out_ready) carries at most one word per input byte: a kept
// byte, or a bare end mark (byte_valid low) when the final byte is not
// emitted. found and truncated are meaningful only with out_last.
// The configuration channel (cfg_valid/cfg_ready) writes target_tag at
// index 0 and find_mode at index 1; it is always ready and should be used
// only while no stream word is in flight.
// An accepted byte goes to the input register, its result to the result
// register. One byte is taken every cycle unless a stalled receiver blocks a
// result; the rate is set by the single parse step between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more byte; bytes that give no result
// keep flowing until a result needs the occupied result register.
// Reset clears both registers' valid flags, the parser state and the
// configuration registers (target_tag 0, remove mode).
`timescale 1ns / 1ps
`default_nettype none

module tlv_record_filter_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            out_last,
  output logic            found,
  output logic            truncated,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  tlvf_pkg::cfg_t    cfg;
  tlvf_pkg::item_t   item_in;
  tlvf_pkg::item_t   item;
  tlvf_pkg::result_t result_next;
  tlvf_pkg::result_t result;
  logic              item_valid;
  logic              has_result;
  logic              out_free;
  logic              advance;
  logic              in_load;
  logic              out_load;

  // Configuration registers; writes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_tag <= '0;
      cfg.find_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlvf_pkg::REG_TARGET_TAG: cfg.target_tag <= cfg_data;
        tlvf_pkg::REG_FIND_MODE:  cfg.find_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: the held word moves on unless its result is
  // blocked by a full result register.
  assign advance  = item_valid && (!has_result || out_free);
  assign out_load = item_valid && has_result && out_free;
  assign in_ready = !item_valid || advance;
  assign in_load  = in_valid && in_ready;

  assign item_in.data = in_byte;
  assign item_in.last = in_last;

  tlvf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_load),
    .drain      (advance),
    .item_in    (item_in),
    .item       (item),
    .item_valid (item_valid)
  );

  tlvf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .advance    (advance),
    .has_result (has_result),
    .result     (result_next)
  );

  tlvf_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .result_in    (result_next),
    .take         (out_ready),
    .result       (result),
    .result_valid (out_valid),
    .free         (out_free)
  );

  // Output fields.
  assign out_byte   = result.data;
  assign byte_valid = result.byte_valid;
  assign out_last   = result.last;
  assign found      = result.found;
  assign truncated  = result.truncated;

endmodule

`default_nettype wire

>>> rtl/core/tlvf_checker.sv
// Port-level checks for the record filter, bound to the top level.
// Depends on tlv_record_filter_unit_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "tlv_record_filter_unit_macros.svh"

module tlvf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       out_last,
  input wire logic       found,
  input wire logic       truncated
);

  // A stalled word stays on the output unchanged.
  `TLVF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(out_last) && $stable(found) && $stable(truncated), "output word changed while stalled")

  // The stream flags only travel with the end mark.
  `TLVF_ASSERT_IMP(a_flags_at_end, clk, rst, out_valid && !out_last, !found && !truncated, "found or truncated set without end mark")

  // A word with no data is always a bare end mark with a zero byte.
  `TLVF_ASSERT_IMP(a_bare_end, clk, rst, out_valid && !byte_valid, out_last && (out_byte == 8'd0), "empty word that is not a clean end mark")

  // Nothing is offered in the first cycle after reset.
  `TLVF_ASSERT_IMP(a_reset_idle, clk, rst, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind tlv_record_filter_unit tlvf_checker u_tlvf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .out_last   (out_last),
  .found      (found),
  .truncated  (truncated)
);

`default_nettype wire
